// ===== hw/rtl/ptts_pkg.sv =====
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and constants for the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

    // table and result sizing
    localparam int MAX_TASKS  = 16;
    localparam int RESULT_CAP = 16;
    localparam int IDX_W      = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W      = $clog2(MAX_TASKS + 1);
    localparam int RCNT_W     = $clog2(RESULT_CAP + 1);

    // field widths
    localparam int ACT_W  = 2;
    localparam int ID_W   = 8;
    localparam int TICK_W = 32;
    localparam int ST_W   = 2;
    localparam int BIT_W  = $clog2(TICK_W);

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK   = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } t_status;

    typedef struct packed {
        t_action            action;
        logic [ID_W-1:0]    ident;
        logic [TICK_W-1:0]  period;
    } t_cmd;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RESP,
        BK_T_NEXT,
        BK_T_DIV,
        BK_T_CHECK,
        BK_R_SCAN
    } t_back_state;

endpackage

// ===== hw/rtl/ptts_in_if.sv =====
// ----------------------------------------------------------------------------
// ptts_in_if
// Input channel: one action with its task id and period per transfer.
// ----------------------------------------------------------------------------
interface ptts_in_if;
    import ptts_pkg::*;

    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [ID_W-1:0]    task_ident;
    logic [TICK_W-1:0]  task_period;

    modport source (output valid, output action, output task_ident, output task_period,
                    input ready);
    modport sink   (input valid, input action, input task_ident, input task_period,
                    output ready);
endinterface

// ===== hw/rtl/ptts_out_if.sv =====
// ----------------------------------------------------------------------------
// ptts_out_if
// Result channel: one firing or status report per transfer.
// ----------------------------------------------------------------------------
interface ptts_out_if;
    import ptts_pkg::*;

    logic             valid;
    logic             ready;
    logic [ID_W-1:0]  fired_ident;
    logic             fired;
    logic [ST_W-1:0]  status;
    logic             last;

    modport source (output valid, output fired_ident, output fired, output status,
                    output last, input ready);
    modport sink   (input valid, input fired_ident, input fired, input status,
                    input last, output ready);
endinterface

// ===== hw/rtl/periodic_task_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Ordered task table with a modulo tick; fires due tasks in table order.
// ----------------------------------------------------------------------------
// Add, remove and the unused action code each give one status result; remove
// searches the table entry by entry. A tick gives one result per firing task
// in table order (last marks the final one) or a single empty result, and
// tests each table entry with a nonzero period for divisibility in one
// bit-serial remainder unit that retires one bit of the tick counter per
// cycle. One command is executed at a time; a two-entry command queue and a
// staging register let the input keep taking transfers while a result waits
// at the output.
module periodic_task_tick_scheduler import ptts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptts_in_if.sink     i_in,
    ptts_out_if.source  o_out
);

    t_cmd              fr_cmd;
    logic              fr_valid;
    logic              fr_ready;
    t_cmd              q_cmd;
    logic              q_valid;
    logic              q_ready;
    logic [CNT_W-1:0]  entry_count;

    // decode and stage
    ptts_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (fr_cmd),
        .o_cmd_valid (fr_valid),
        .i_cmd_ready (fr_ready)
    );

    // command queue
    ptts_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_cmd   (fr_cmd),
        .i_push_valid (fr_valid),
        .o_push_ready (fr_ready),
        .o_pop_cmd    (q_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready)
    );

    // execution
    ptts_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (q_cmd),
        .i_cmd_valid   (q_valid),
        .o_cmd_ready   (q_ready),
        .o_out         (o_out),
        .o_entry_count (entry_count)
    );

`ifndef ASSERT_OFF
    // table never holds more than its capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        entry_count <= CNT_W'(MAX_TASKS))
        else $error("entry count above capacity");

    // a non-firing result always closes its command
    a_nofire_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.fired) |-> o_out.last)
        else $error("non-firing result without last");

    // an error status never comes with a firing
    a_status_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_OK) |-> !o_out.fired)
        else $error("error status on a firing result");
`endif

endmodule

// ===== hw/rtl/ptts_front.sv =====
// ----------------------------------------------------------------------------
// ptts_front
// Accepts input transfers, decodes the action and stages one command.
// ----------------------------------------------------------------------------
module ptts_front import ptts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptts_in_if.sink     i_in,
    output t_cmd        o_cmd,
    output logic        o_cmd_valid,
    input  logic        i_cmd_ready
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    // stage is free when empty or draining this cycle
    assign i_in.ready = !r_valid || i_cmd_ready;

    // classify the action code
    always_comb begin
        n_cmd.ident  = i_in.task_ident;
        n_cmd.period = i_in.task_period;
        case (i_in.action)
            ACT_TICK:   n_cmd.action = ACT_TICK;
            ACT_ADD:    n_cmd.action = ACT_ADD;
            ACT_REMOVE: n_cmd.action = ACT_REMOVE;
            default:    n_cmd.action = ACT_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd       = r_cmd;
    assign o_cmd_valid = r_valid;

endmodule

// ===== hw/rtl/ptts_queue.sv =====
// ----------------------------------------------------------------------------
// ptts_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module ptts_queue import ptts_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_push_cmd,
    input  logic   i_push_valid,
    output logic   o_push_ready,
    output t_cmd   o_pop_cmd,
    output logic   o_pop_valid,
    input  logic   i_pop_ready
);

    t_cmd               r_mem [Q_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_cnt;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_cnt != QCNT_W'(Q_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ===== hw/rtl/ptts_back.sv =====
// ----------------------------------------------------------------------------
// ptts_back
// Executes commands: task table, tick counter, bit-serial remainder unit and
// the result register.
// ----------------------------------------------------------------------------
module ptts_back import ptts_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    ptts_out_if.source        o_out,
    output logic [CNT_W-1:0]  o_entry_count
);

    t_back_state        r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    t_status            r_status, n_status;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [TICK_W-1:0]  r_tick, n_tick;
    logic [TICK_W-1:0]  r_rem, n_rem;
    logic [TICK_W-1:0]  r_dvd, n_dvd;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic               r_pend, n_pend;
    logic [ID_W-1:0]    r_pend_id, n_pend_id;
    logic [RCNT_W-1:0]  r_nfire, n_nfire;

    logic [ID_W-1:0]    r_ident  [MAX_TASKS];
    logic [TICK_W-1:0]  r_period [MAX_TASKS];

    logic               r_out_valid;
    logic [ID_W-1:0]    r_out_ident;
    logic               r_out_fired;
    t_status            r_out_status;
    logic               r_out_last;

    logic               slot_free;
    logic               emit;
    logic [ID_W-1:0]    e_ident;
    logic               e_fired;
    t_status            e_status;
    logic               e_last;
    logic               add_en;
    logic               shift_en;
    logic [IDX_W-1:0]   rd_idx;
    logic [ID_W-1:0]    cur_ident;
    logic [TICK_W-1:0]  cur_period;
    logic [TICK_W:0]    trial;
    logic [TICK_W:0]    diff;

    assign slot_free  = !r_out_valid || o_out.ready;
    assign rd_idx     = r_idx[IDX_W-1:0];
    assign cur_ident  = r_ident[rd_idx];
    assign cur_period = r_period[rd_idx];

    // one restoring remainder step
    assign trial = {r_rem, r_dvd[TICK_W-1]};
    assign diff  = trial - {1'b0, cur_period};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_count <= '0;
            r_tick  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_tick  <= n_tick;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_status  <= n_status;
        r_idx     <= n_idx;
        r_rem     <= n_rem;
        r_dvd     <= n_dvd;
        r_bit     <= n_bit;
        r_pend_id <= n_pend_id;
        r_nfire   <= n_nfire;
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_status  = r_status;
        n_idx     = r_idx;
        n_count   = r_count;
        n_tick    = r_tick;
        n_rem     = r_rem;
        n_dvd     = r_dvd;
        n_bit     = r_bit;
        n_pend    = r_pend;
        n_pend_id = r_pend_id;
        n_nfire   = r_nfire;
        o_cmd_ready = 1'b0;
        emit      = 1'b0;
        e_ident   = '0;
        e_fired   = 1'b0;
        e_status  = ST_OK;
        e_last    = 1'b1;
        add_en    = 1'b0;
        shift_en  = 1'b0;
        case (r_state)
            BK_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_cmd   = i_cmd;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_nfire = '0;
                    case (i_cmd.action)
                        ACT_TICK: begin
                            n_state = BK_T_NEXT;
                        end
                        ACT_ADD: begin
                            if (r_count >= CNT_W'(MAX_TASKS)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status = ST_OK;
                                add_en   = 1'b1;
                                n_count  = r_count + 1'b1;
                            end
                            n_state = BK_RESP;
                        end
                        ACT_REMOVE: begin
                            n_state = BK_R_SCAN;
                        end
                        default: begin
                            n_status = ST_OK;
                            n_state  = BK_RESP;
                        end
                    endcase
                end
            end
            BK_RESP: begin
                if (slot_free) begin
                    emit     = 1'b1;
                    e_status = r_status;
                    n_state  = BK_IDLE;
                end
            end
            BK_T_NEXT: begin
                if (r_idx >= r_count || r_nfire == RCNT_W'(RESULT_CAP)) begin
                    // close the tick with the held firing or an empty report
                    if (slot_free) begin
                        emit    = 1'b1;
                        e_ident = r_pend ? r_pend_id : '0;
                        e_fired = r_pend;
                        n_pend  = 1'b0;
                        n_tick  = r_tick + 1'b1;
                        n_state = BK_IDLE;
                    end
                end else if (cur_period == '0) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_rem   = '0;
                    n_dvd   = r_tick;
                    n_bit   = '0;
                    n_state = BK_T_DIV;
                end
            end
            BK_T_DIV: begin
                n_rem = diff[TICK_W] ? trial[TICK_W-1:0] : diff[TICK_W-1:0];
                n_dvd = {r_dvd[TICK_W-2:0], 1'b0};
                n_bit = r_bit + 1'b1;
                if (r_bit == BIT_W'(TICK_W - 1)) begin
                    n_state = BK_T_CHECK;
                end
            end
            BK_T_CHECK: begin
                if (r_rem != '0) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = BK_T_NEXT;
                end else if (!r_pend || slot_free) begin
                    // release the previous firing, hold this one
                    emit      = r_pend;
                    e_ident   = r_pend_id;
                    e_fired   = 1'b1;
                    e_last    = 1'b0;
                    n_pend    = 1'b1;
                    n_pend_id = cur_ident;
                    n_nfire   = r_nfire + 1'b1;
                    n_idx     = r_idx + 1'b1;
                    n_state   = BK_T_NEXT;
                end
            end
            BK_R_SCAN: begin
                if (r_idx >= r_count) begin
                    n_status = ST_ABSENT;
                    n_state  = BK_RESP;
                end else if (cur_ident == r_cmd.ident) begin
                    shift_en = 1'b1;
                    n_count  = r_count - 1'b1;
                    n_status = ST_OK;
                    n_state  = BK_RESP;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // task table: append at the end, close the gap on removal
    always_ff @(posedge i_clk) begin
        if (add_en) begin
            r_ident[r_count[IDX_W-1:0]]  <= n_cmd.ident;
            r_period[r_count[IDX_W-1:0]] <= n_cmd.period;
        end
        if (shift_en) begin
            for (int j = 0; j < MAX_TASKS - 1; j++) begin
                if (CNT_W'(j) >= r_idx) begin
                    r_ident[j]  <= r_ident[j + 1];
                    r_period[j] <= r_period[j + 1];
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_ident  <= e_ident;
            r_out_fired  <= e_fired;
            r_out_status <= e_status;
            r_out_last   <= e_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.fired_ident = r_out_ident;
    assign o_out.fired       = r_out_fired;
    assign o_out.status      = r_out_status;
    assign o_out.last        = r_out_last;
    assign o_entry_count     = r_count;

endmodule

// ===== tb/sv/ptts_scoreboard.sv =====
// ----------------------------------------------------------------------------
// ptts_scoreboard
// Table and tick-counter predictor with a queue of expected scheduler results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import ptts_pkg::*;

class ptts_scoreboard;

    typedef struct {
        logic [ID_W-1:0] fired_ident;
        logic            fired;
        t_status         status;
        logic            last;
    } t_report;

    logic [TICK_W-1:0] tick_count;
    logic [ID_W-1:0]   task_ids[$];
    logic [TICK_W-1:0] task_periods[$];
    t_report           pending[$];
    int                mismatches;

    function void clear();
        tick_count   = '0;
        task_ids     = {};
        task_periods = {};
        pending      = {};
        mismatches   = 0;
    endfunction

    function void push_report(logic [ID_W-1:0] id, logic f, t_status st, logic l);
        t_report r;
        r.fired_ident = id;
        r.fired       = f;
        r.status      = st;
        r.last        = l;
        pending.push_back(r);
    endfunction

    // apply one accepted command to the table and queue its results
    function void note_command(t_action act, logic [ID_W-1:0] id, logic [TICK_W-1:0] per);
        int n;
        int hit;
        n   = 0;
        hit = -1;
        case (act)
            ACT_TICK: begin
                foreach (task_ids[i]) begin
                    if (task_periods[i] != 0 && tick_count % task_periods[i] == 0
                        && n < RESULT_CAP) begin
                        push_report(task_ids[i], 1'b1, ST_OK, 1'b0);
                        n++;
                    end
                end
                tick_count = tick_count + 1;
                if (n == 0) push_report('0, 1'b0, ST_OK, 1'b1);
                else pending[pending.size()-1].last = 1'b1;
            end
            ACT_ADD: begin
                if (task_ids.size() >= MAX_TASKS) begin
                    push_report('0, 1'b0, ST_FULL, 1'b1);
                end else begin
                    task_ids.push_back(id);
                    task_periods.push_back(per);
                    push_report('0, 1'b0, ST_OK, 1'b1);
                end
            end
            ACT_REMOVE: begin
                foreach (task_ids[i]) if (hit < 0 && task_ids[i] == id) hit = i;
                if (hit >= 0) begin
                    task_ids.delete(hit);
                    task_periods.delete(hit);
                    push_report('0, 1'b0, ST_OK, 1'b1);
                end else begin
                    push_report('0, 1'b0, ST_ABSENT, 1'b1);
                end
            end
            default: push_report('0, 1'b0, ST_OK, 1'b1);
        endcase
    endfunction

    function void check_report(logic [ID_W-1:0] id, logic f, logic [ST_W-1:0] st, logic l);
        t_report e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: id %0d fired %0b status %0d last %0b",
                         id, f, st, l);
            return;
        end
        e = pending.pop_front();
        if (id !== e.fired_ident || f !== e.fired || st !== e.status || l !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"result mismatch: exp id %0d fired %0b status %0d last %0b,",
                          " got id %0d fired %0b status %0d last %0b"},
                         e.fired_ident, e.fired, e.status, e.last, id, f, st, l);
        end
    endfunction
endclass

// ===== tb/sv/periodic_task_tick_scheduler_test.sv =====
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_test
// Drives add, remove, tick and unused commands with bursty input and a
// stalling result side; every result is checked against a table predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_test;
    import ptts_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ptts_in_if  in_ch();
    ptts_out_if out_ch();

    periodic_task_tick_scheduler uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    ptts_scoreboard table_model;
    int  idle_cycles = 0;
    bit  hold_off    = 1'b0;
    int  burst_left  = 0;
    logic [ID_W-1:0] used_ids[$];

    always #2 i_clk = ~i_clk;

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.action      = ACT_TICK;
        in_ch.task_ident  = '0;
        in_ch.task_period = '0;
        out_ch.ready      = 1'b0;
        table_model = new();
        table_model.clear();
    end

    // result side: check transfers and stall on its own pattern
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            table_model.check_report(out_ch.fired_ident, out_ch.fired, out_ch.status,
                                     out_ch.last);
        if (hold_off) out_ch.ready <= 1'b0;
        else if ($urandom_range(0, 99) < 15) out_ch.ready <= ~out_ch.ready;
        else if (!out_ch.ready && $urandom_range(0, 3) == 0) out_ch.ready <= 1'b1;
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("periodic_task_tick_scheduler regression: fail");
            $finish;
        end
    end

    // offer one command and wait for its transfer, with bursty gaps before it
    task automatic send_command(t_action act, logic [ID_W-1:0] id, logic [TICK_W-1:0] per);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.task_ident  <= id;
        in_ch.task_period <= per;
        do @(posedge i_clk); while (!in_ch.ready);
        table_model.note_command(act, id, per);
        if (act == ACT_ADD) used_ids.push_back(id);
    endtask

    function automatic logic [TICK_W-1:0] pick_period();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom();
            2:       return 32'hFFFF_FFFF;
            default: return TICK_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_ident();
        if (used_ids.size() > 0 && $urandom_range(0, 3) != 0)
            return used_ids[$urandom_range(0, used_ids.size() - 1)];
        return ID_W'($urandom_range(0, 255));
    endfunction

    // long receiver stall while commands keep coming
    initial begin
        wait (i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        int k;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty tick, extremes, duplicates, zero period, full table
        send_command(ACT_TICK, 8'd0, '0);
        send_command(ACT_REMOVE, 8'd255, '0);
        send_command(ACT_ADD, 8'd0, 32'd1);
        send_command(ACT_ADD, 8'd255, 32'hFFFF_FFFF);
        send_command(ACT_ADD, 8'd7, 32'd0);
        send_command(ACT_ADD, 8'd0, 32'd2);
        send_command(ACT_TICK, 8'hAA, 32'h5555_5555);
        send_command(ACT_TICK, 8'h55, 32'hAAAA_AAAA);
        send_command(ACT_NONE, 8'hFF, 32'hFFFF_FFFF);
        send_command(ACT_REMOVE, 8'd0, '0);
        send_command(ACT_TICK, 8'd0, '0);
        for (k = 0; k < 14; k++) send_command(ACT_ADD, k[7:0] + 8'd100, 32'd1);
        send_command(ACT_ADD, 8'd1, 32'd1);
        send_command(ACT_TICK, 8'd0, '0);

        // random: mostly ticks and table churn
        for (k = 0; k < 94; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send_command(ACT_TICK, ID_W'($urandom_range(0, 255)), $urandom());
                4, 5, 6:    send_command(ACT_ADD, pick_ident(), pick_period());
                7, 8:       send_command(ACT_REMOVE, pick_ident(), $urandom());
                default:    send_command(ACT_NONE, ID_W'($urandom_range(0, 255)), $urandom());
            endcase
        end
        in_ch.valid <= 1'b0;

        while (table_model.pending.size() != 0) @(posedge i_clk);
        repeat (700) @(posedge i_clk);
        if (table_model.mismatches == 0 && table_model.pending.size() == 0) begin
            $display("periodic_task_tick_scheduler regression: pass");
        end else begin
            $display("periodic_task_tick_scheduler regression: fail");
        end
        $finish;
    end
endmodule
